// ----- src/lifo_rbv_pkg.sv -----
// ============================================================================
// lifo_rbv_pkg: shared types and constants for the LIFO with remove-by-value
// Command and status codes, request/response payloads, the cell control word.
// ============================================================================
package lifo_rbv_pkg;

    localparam int CMD_W  = 2;
    localparam int ITEM_W = 32;   // item field width on the ports
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PULL = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ITEM_W-1:0] item_value;
    } in_req_t;

    typedef struct packed {
        logic [ITEM_W-1:0] out_item;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } out_rsp_t;

    // Broadcast to every cell for one request.
    typedef struct packed {
        logic push;       // push accepted (store not full): shift toward the bottom
        logic pop;        // pop accepted (store not empty): shift toward the top
        logic pull_hit;   // pull found a match somewhere in the row
    } cell_ctrl_t;

endpackage

// ----- src/lifo_rbv_cell.sv -----
// ============================================================================
// lifo_rbv_cell: one storage cell of the LIFO row
// Holds one entry and its valid bit, compares against the search key and
// takes its neighbor's entry on push, pop or removal.
// ============================================================================
module lifo_rbv_cell #(
    parameter int W = lifo_rbv_pkg::ITEM_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lifo_rbv_pkg::cell_ctrl_t ctrl,
    input  logic [W-1:0]             key,
    input  logic [W-1:0]             up_data,      // neighbor nearer the top
    input  logic                     up_valid,
    input  logic [W-1:0]             dn_data,      // neighbor nearer the bottom
    input  logic                     dn_valid,
    input  logic                     match_in,     // some older cell matches
    output logic                     match_out,
    output logic [W-1:0]             data,
    output logic                     valid
);

    logic [W-1:0] data_reg, data_next;
    logic         valid_reg, valid_next;
    logic         shift_dn;

    assign match_out = match_in | (valid_reg & (data_reg == key));

    // Pull removes the oldest match: this cell and all older ones close the gap.
    assign shift_dn = ctrl.pop | (ctrl.pull_hit & ~match_in);

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.push) begin
            data_next  = up_data;
            valid_next = up_valid;
        end else if (shift_dn) begin
            data_next  = dn_data;
            valid_next = dn_valid;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ----- src/lifo_rbv_top_dummy.sv -----
// ============================================================================
// lifo_rbv_resp: response builder for the LIFO row
// Forms status, popped item, new occupancy and the cell control word, and keeps the entry count.
// ============================================================================
module lifo_rbv_resp #(
    parameter int DEPTH = lifo_rbv_pkg::DEPTH_DEF,
    parameter int W     = lifo_rbv_pkg::ITEM_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     take,        // request accepted this cycle
    input  lifo_rbv_pkg::in_req_t    req,
    input  logic                     empty,
    input  logic                     full,
    input  logic                     any_match,
    input  logic [W-1:0]             top_data,
    output lifo_rbv_pkg::cell_ctrl_t ctrl,
    output lifo_rbv_pkg::out_rsp_t   rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]      top_wide;

    always_comb begin
        ctrl          = '0;
        rsp.out_item  = '0;
        rsp.status    = lifo_rbv_pkg::ST_DONE;
        cnt_next      = cnt_reg;
        top_wide      = 64'(top_data);
        case (req.command)
            lifo_rbv_pkg::CMD_PUSH: begin
                if (full) begin
                    rsp.status = lifo_rbv_pkg::ST_FULL;
                end else begin
                    ctrl.push = take;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            lifo_rbv_pkg::CMD_POP: begin
                if (empty) begin
                    rsp.status = lifo_rbv_pkg::ST_EMPTY;
                end else begin
                    ctrl.pop     = take;
                    rsp.out_item = top_wide[lifo_rbv_pkg::ITEM_W-1:0];
                    cnt_next     = cnt_reg - CNT_W'(1);
                end
            end
            lifo_rbv_pkg::CMD_PULL: begin
                if (any_match) begin
                    ctrl.pull_hit = take;
                    cnt_next      = cnt_reg - CNT_W'(1);
                end else begin
                    rsp.status = lifo_rbv_pkg::ST_NOMATCH;
                end
            end
            default: begin
            end
        endcase
        rsp.occupancy = (lifo_rbv_pkg::OCC_W)'(cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (take) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/lifo_stack_with_remove_by_value.sv -----
// ============================================================================
// lifo_stack_with_remove_by_value: bounded LIFO of item handles
// Push, pop and remove-by-value over a row of shifting storage cells.
// ============================================================================
// Usage:
//   s_ channel carries one request {command, item_value}: push (0), pop (1),
//   pull (2, remove the oldest entry equal to item_value); code 3 is a no-op.
//   m_ channel returns exactly one response per request, in order:
//   {out_item, status, occupancy}. status is done, pop on empty, push on
//   full (item dropped) or pull with no match; occupancy is the entry count
//   after the request.
//   The store is a row of DEPTH cells, top of stack in cell 0. Push shifts
//   the row toward the bottom; pop and pull shift toward the top, pull only
//   from the removed cell down to the bottom cell. Every cell compares its
//   entry with the key at once, and a match flag ripples from the bottom
//   cell to the top, so the oldest match is the one removed.
//   The response is registered, valid in the cycle after acceptance.
//   Throughput: one request per cycle unless the receiver stalls; each request
//   completes in the accept cycle, updating cells, entry count and output register.
//   When the receiver stalls, the response is held in the output register
//   and s_ready drops until it is taken; s_ready stays high in the cycle the
//   held response is taken.
//   Reset (aresetn low, synchronous) empties the store and the output
//   register; entry contents are not cleared.
// ============================================================================
module lifo_stack_with_remove_by_value #(
    parameter int DEPTH      = lifo_rbv_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = lifo_rbv_pkg::ITEM_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lifo_rbv_pkg::in_req_t  s_req,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lifo_rbv_pkg::out_rsp_t m_rsp
);

    logic [ITEM_WIDTH-1:0] data [DEPTH];
    logic                  valid[DEPTH];
    logic                  match[DEPTH+1];   // match[j]: some cell at index >= j matches

    lifo_rbv_pkg::cell_ctrl_t ctrl;
    lifo_rbv_pkg::out_rsp_t   rsp, rsp_reg;
    logic                     m_valid_reg;
    logic                     take;
    logic [63:0]              key_wide;
    logic [ITEM_WIDTH-1:0]    key;

    // Key is the low ITEM_WIDTH bits of the request item, zero-extended.
    assign key_wide = 64'(s_req.item_value);
    assign key      = key_wide[ITEM_WIDTH-1:0];

    // Output register: accept whenever the held response leaves or none is held.
    assign s_ready = ~m_valid_reg | m_ready;
    assign take    = s_valid & s_ready;

    assign match[DEPTH] = 1'b0;

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [ITEM_WIDTH-1:0] up_d, dn_d;
        logic                  up_v, dn_v;

        if (j == 0) begin : g_top
            assign up_d = key;             // push enters at the top
            assign up_v = 1'b1;
        end else begin : g_mid_up
            assign up_d = data[j-1];
            assign up_v = valid[j-1];
        end

        if (j == DEPTH - 1) begin : g_bot
            assign dn_d = '0;              // bottom cell empties on a shift up
            assign dn_v = 1'b0;
        end else begin : g_mid_dn
            assign dn_d = data[j+1];
            assign dn_v = valid[j+1];
        end

        lifo_rbv_cell #(
            .W (ITEM_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .key       (key),
            .up_data   (up_d),
            .up_valid  (up_v),
            .dn_data   (dn_d),
            .dn_valid  (dn_v),
            .match_in  (match[j+1]),
            .match_out (match[j]),
            .data      (data[j]),
            .valid     (valid[j])
        );
    end

    lifo_rbv_resp #(
        .DEPTH (DEPTH),
        .W     (ITEM_WIDTH)
    ) u_resp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .req       (s_req),
        .empty     (~valid[0]),
        .full      (valid[DEPTH-1]),
        .any_match (match[0]),
        .top_data  (data[0]),
        .ctrl      (ctrl),
        .rsp       (rsp)
    );

    always_ff @(posedge aclk) begin
        if (take) begin
            rsp_reg <= rsp;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

endmodule

// ----- verif/lifo_stack_with_remove_by_value_test.sv -----
// ============================================================================
// lifo_stack_with_remove_by_value_test: self-checking bench for the LIFO
// Drives push, pop, pull and no-op requests through the s_ channel, predicts
// each response with a behavioral copy of the store, and checks every m_
// response in order. Directed corner cases first, then random traffic under
// changing backpressure.
// ============================================================================
module lifo_stack_with_remove_by_value_test;

    localparam int STACK_DEPTH = lifo_rbv_pkg::DEPTH_DEF;
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED = 100;

    // Code 3 has no name in the package; the block treats it as a no-op.
    localparam logic [lifo_rbv_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    lifo_rbv_pkg::in_req_t  s_req   = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    lifo_rbv_pkg::out_rsp_t m_rsp;

    lifo_stack_with_remove_by_value uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shadow store: entry 0 is the oldest, the top sits at shadow_count-1.
    // ------------------------------------------------------------------------
    logic [lifo_rbv_pkg::ITEM_W-1:0] shadow_mem [STACK_DEPTH];
    int                              shadow_count = 0;

    lifo_rbv_pkg::in_req_t  request_q  [$];   // requests not yet offered
    lifo_rbv_pkg::out_rsp_t response_q [$];   // predicted responses, oldest first
    int       total_requests = 0;
    int       accepted_count = 0;
    int       error_count    = 0;
    logic     hold_rx        = 1'b0;

    // Apply one request to the shadow store and return the response it gives.
    function automatic lifo_rbv_pkg::out_rsp_t lifo_apply(lifo_rbv_pkg::in_req_t req);
        lifo_rbv_pkg::out_rsp_t rsp;
        int                     hit;
        rsp = '0;
        rsp.status = lifo_rbv_pkg::ST_DONE;
        case (req.command)
            lifo_rbv_pkg::CMD_PUSH: begin
                if (shadow_count == STACK_DEPTH) begin
                    rsp.status = lifo_rbv_pkg::ST_FULL;   // dropped, store untouched
                end else begin
                    shadow_mem[shadow_count] = req.item_value;
                    shadow_count++;
                end
            end
            lifo_rbv_pkg::CMD_POP: begin
                if (shadow_count == 0) begin
                    rsp.status = lifo_rbv_pkg::ST_EMPTY;
                end else begin
                    shadow_count--;
                    rsp.out_item = shadow_mem[shadow_count];
                end
            end
            lifo_rbv_pkg::CMD_PULL: begin
                // oldest match wins; later entries close the gap
                hit = -1;
                for (int i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_mem[i] == req.item_value)
                        hit = i;
                if (hit < 0) begin
                    rsp.status = lifo_rbv_pkg::ST_NOMATCH;
                end else begin
                    for (int j = hit + 1; j < shadow_count; j++)
                        shadow_mem[j-1] = shadow_mem[j];
                    shadow_count--;
                end
            end
            default: ;   // no-op
        endcase
        rsp.occupancy = (lifo_rbv_pkg::OCC_W)'(shadow_count);
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [lifo_rbv_pkg::ITEM_W-1:0] got,
                                   logic [lifo_rbv_pkg::ITEM_W-1:0] want);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH %s: got %h, expected %h (response %0d)",
                     what, got, want, accepted_count);
        error_count++;
    endtask

    task automatic add_request(logic [lifo_rbv_pkg::CMD_W-1:0] cmd,
                               logic [lifo_rbv_pkg::ITEM_W-1:0] value);
        lifo_rbv_pkg::in_req_t req;
        req.command    = cmd;
        req.item_value = value;
        request_q.push_back(req);
        total_requests++;
    endtask

    // Idle percentages per phase: receiver-heavy gaps, then sender-heavy,
    // then full rate. Phase follows the number of accepted requests.
    function automatic int tx_idle_pct();
        if (hold_rx)                              return 0;
        if (accepted_count < total_requests / 3)  return 22;
        if (accepted_count < 2 * total_requests / 3) return 59;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (accepted_count < total_requests / 3)  return 59;
        if (accepted_count < 2 * total_requests / 3) return 22;
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the next request once the slot is free, predicts on
    // acceptance. s_valid and s_req get one assignment per edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                response_q.push_back(lifo_apply(s_req));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
                    s_valid <= 1'b1;
                    s_req   <= request_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure; a long hold-off stalls the block's input.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct());
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted response against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        lifo_rbv_pkg::out_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (response_q.size() == 0) begin
                report_mismatch("unexpected response", m_rsp.out_item, '0);
            end else begin
                want = response_q.pop_front();
                if (m_rsp.out_item !== want.out_item)
                    report_mismatch("out_item", m_rsp.out_item, want.out_item);
                if (m_rsp.status !== want.status)
                    report_mismatch("status", (lifo_rbv_pkg::ITEM_W)'(m_rsp.status),
                                    (lifo_rbv_pkg::ITEM_W)'(want.status));
                if (m_rsp.occupancy !== want.occupancy)
                    report_mismatch("occupancy", (lifo_rbv_pkg::ITEM_W)'(m_rsp.occupancy),
                                    (lifo_rbv_pkg::ITEM_W)'(want.occupancy));
            end
        end
    end

    // Long receiver stall in the middle of the run, counted here.
    initial begin
        while (accepted_count < 400)
            @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Run limit, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("lifo_stack_with_remove_by_value_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [lifo_rbv_pkg::ITEM_W-1:0] key_pool [8];
        int                              push_pct;
        int                              pick;
        logic [lifo_rbv_pkg::ITEM_W-1:0] value;

        // Directed: empty store first.
        add_request(lifo_rbv_pkg::CMD_POP,  32'hDEAD_BEEF);   // pop on empty
        add_request(lifo_rbv_pkg::CMD_PULL, 32'h0000_0000);   // pull on empty: no match
        add_request(CMD_NOP,                32'hFFFF_FFFF);   // unused code at empty
        // Fill to the brim, with extremes and a duplicated handle.
        add_request(lifo_rbv_pkg::CMD_PUSH, 32'h0000_0000);
        add_request(lifo_rbv_pkg::CMD_PUSH, 32'hFFFF_FFFF);
        add_request(lifo_rbv_pkg::CMD_PUSH, 32'hA5A5_A5A5);
        add_request(lifo_rbv_pkg::CMD_PUSH, 32'h1234_5678);
        for (int k = 4; k < STACK_DEPTH; k++)
            add_request(lifo_rbv_pkg::CMD_PUSH,
                        (k == 10) ? 32'h1234_5678 : (32'h1 << (k + 12)));
        add_request(lifo_rbv_pkg::CMD_PUSH, 32'h5A5A_5A5A);   // push on full: dropped
        add_request(CMD_NOP,                32'h0000_0000);   // unused code at full
        add_request(lifo_rbv_pkg::CMD_PULL, 32'h1234_5678);   // duplicate: oldest copy goes
        add_request(lifo_rbv_pkg::CMD_PULL, 32'h5A5A_5A5A);   // never stored: no match
        add_request(lifo_rbv_pkg::CMD_PULL, 32'h0000_0000);   // bottom entry removed
        add_request(lifo_rbv_pkg::CMD_POP,  32'h0000_0000);   // top after the shifts

        // Random: keys mostly from a small pool so pulls hit and duplicates
        // stack up; push share changes every 50 requests to sweep occupancy.
        for (int k = 0; k < 6; k++)
            key_pool[k] = $urandom;
        key_pool[6] = '0;
        key_pool[7] = '1;
        push_pct = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            value = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(7)];
            pick  = $urandom_range(99);
            if (pick < 3)
                add_request(CMD_NOP, $urandom);
            else if (pick < 3 + push_pct)
                add_request(lifo_rbv_pkg::CMD_PUSH, value);
            else if (pick % 2 == 0)
                add_request(lifo_rbv_pkg::CMD_POP, $urandom);
            else
                add_request(lifo_rbv_pkg::CMD_PULL, value);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < total_requests)
            @(posedge aclk);
        while (response_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("lifo_stack_with_remove_by_value_test: done, clean");
        else
            $display("lifo_stack_with_remove_by_value_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/lifo_rbv_pkg.sv
src/lifo_rbv_cell.sv
src/lifo_rbv_top_dummy.sv
src/lifo_stack_with_remove_by_value.sv
verif/lifo_stack_with_remove_by_value_test.sv
